// ===== hw/rtl/sadt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sadt_pkg: shared types and constants
// Character codes, divide-by-ten constants and the queued job word used by
// the signed binary to ASCII decimal converter.
// ----------------------------------------------------------------------------
package sadt_pkg;

   // ASCII characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // n / 10 == (n * RECIP_TEN) >> DIV_SHIFT for every 32-bit n
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int          DIV_SHIFT = 35;

   // Decimal digits of a 32-bit magnitude
   localparam int MAX_DIGITS = 10;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register map
   localparam int          CSR_ADDR_W         = 3;
   localparam logic [2:0]  CSR_TENTHS_MODE    = 3'd0;
   localparam logic        TENTHS_MODE_RESET  = 1'b1;

   // One value after classification
   typedef struct packed {
      logic        neg;
      logic        tenths;
      logic [31:0] mag;
   } job_type;

endpackage
`default_nettype wire

// ===== hw/rtl/sadt_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sadt_fifo: job queue
// Short register queue that decouples the accepting front end from the
// character generating back end.
// ----------------------------------------------------------------------------
module sadt_fifo #(
   parameter int DEPTH = sadt_pkg::QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  sadt_pkg::job_type push_data,
   input  wire               pop,
   output sadt_pkg::job_type head,
   output logic              full,
   output logic              empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   sadt_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not advance on push");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sadt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sadt_front: accept and classify
// Takes one signed value per start pulse while not busy, splits it into sign and unsigned
// magnitude, tags it with the print mode and queues it for the back end.
// ----------------------------------------------------------------------------
module sadt_front #(
   parameter int QUEUE_DEPTH = sadt_pkg::QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire signed [31:0] req_value,
   input  wire               tenths_mode,
   input  wire               pop,
   output sadt_pkg::job_type head,
   output logic              empty
);

   sadt_pkg::job_type job;
   logic              push;
   logic              full;

   // classify: sign and two's complement magnitude
   always_comb begin
      job.neg    = req_value[31];
      job.tenths = tenths_mode;
      job.mag    = req_value[31] ? (~req_value + 32'd1) : req_value;
   end

   assign push = start && !busy;
   assign busy = full;

   sadt_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/sadt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sadt_back: digit generation and character output
// Peels decimal digits off the magnitude one per cycle by reciprocal multiply,
// then sends any minus, the digits and any point and tenths, one word a cycle.
// ----------------------------------------------------------------------------
module sadt_back (
   input  wire               clock,
   input  wire               reset,
   input  sadt_pkg::job_type head,
   input  wire               empty,
   output logic              pop,
   output logic              rsp_valid,
   output logic [7:0]        rsp_text_char,
   output logic              rsp_last_char
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FRAC   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_SIGN   = 3'd3;
   localparam logic [2:0] ST_DIGIT  = 3'd4;
   localparam logic [2:0] ST_POINT  = 3'd5;
   localparam logic [2:0] ST_FOUT   = 3'd6;

   localparam int IW = $clog2(sadt_pkg::MAX_DIGITS);
   localparam int CW = $clog2(sadt_pkg::MAX_DIGITS + 1);

   logic [2:0]    state_ff, state_in;
   logic          neg_ff, neg_in;
   logic          tenths_ff, tenths_in;
   logic [31:0]   mag_ff, mag_in;
   logic [3:0]    frac_ff, frac_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [3:0]    digit_ff [sadt_pkg::MAX_DIGITS];
   logic          dig_we;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [63:0]   prod;
   logic [31:0]   quot;
   logic [31:0]   quot_x10;
   logic [3:0]    rem;

   // divide the magnitude by ten
   assign prod     = 64'(mag_ff) * 64'(sadt_pkg::RECIP_TEN);
   assign quot     = 32'(prod[63:sadt_pkg::DIV_SHIFT]);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem      = 4'(mag_ff - quot_x10);

   assign pop = (state_ff == ST_IDLE) && !empty;

   // sequence the conversion and drive the output word
   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      tenths_in    = tenths_ff;
      mag_in       = mag_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      dig_we       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               neg_in    = head.neg;
               tenths_in = head.tenths;
               mag_in    = head.mag;
               cnt_in    = '0;
               state_in  = head.tenths ? ST_FRAC : ST_DIV;
            end
         end
         ST_FRAC: begin
            frac_in  = rem;
            mag_in   = quot;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dig_we = 1'b1;
            mag_in = quot;
            cnt_in = cnt_ff + 1'b1;
            if (quot == '0) begin
               idx_in   = IW'(cnt_ff);
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = sadt_pkg::CHAR_MINUS;
            state_in     = ST_DIGIT;
         end
         ST_DIGIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = sadt_pkg::CHAR_ZERO + 8'(digit_ff[idx_ff]);
            if (idx_ff == '0) begin
               rsp_last_in = !tenths_ff;
               state_in    = tenths_ff ? ST_POINT : ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_POINT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = sadt_pkg::CHAR_POINT;
            state_in     = ST_FOUT;
         end
         ST_FOUT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = sadt_pkg::CHAR_ZERO + 8'(frac_ff);
            rsp_last_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold job data and output payload
   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      tenths_ff   <= tenths_in;
      mag_ff      <= mag_in;
      frac_ff     <= frac_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // store digits least significant first
   always_ff @(posedge clock) begin
      if (dig_we) begin
         digit_ff[IW'(cnt_ff)] <= rem;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

`ifndef SYNTHESIS
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < CW'(sadt_pkg::MAX_DIGITS))
      else $error("more than ten digits generated");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> CW'(idx_ff) < cnt_ff)
      else $error("digit index beyond stored digits");

   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_char_ff >= sadt_pkg::CHAR_ZERO &&
                                      rsp_char_ff <= sadt_pkg::CHAR_ZERO + 8'd9)
      else $error("final character is not a digit");

   a_point_then_frac: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POINT |=> state_ff == ST_FOUT && rsp_valid_ff &&
                               rsp_char_ff == sadt_pkg::CHAR_POINT)
      else $error("point not followed by tenths digit");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/signed_to_ascii_decimal_tenths.sv =====
`default_nettype none
// A value taken at start passes the queue, the tenths split (tenths mode), the divide loop and the output register.
// The back end handles one value at a time: it splits off the tenths digit in
// tenths mode, runs the one-digit-per-cycle divide-by-ten loop, then sends
// the characters one output word per cycle.
// The receiver cannot stall; a two-entry queue accepts values meanwhile.
// Reset (synchronous) empties the queue and sets tenths_mode to 1.
// ----------------------------------------------------------------------------
// signed_to_ascii_decimal_tenths: signed binary to ASCII decimal
// Prints a signed 32-bit value as decimal text, one character per word,
// either as an integer or as tenths with one decimal place.
// ----------------------------------------------------------------------------
module signed_to_ascii_decimal_tenths #(
   parameter int QUEUE_DEPTH = sadt_pkg::QUEUE_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   // input channel
   input  wire                              start,
   output logic                             busy,
   input  wire signed [31:0]                req_value,
   // result channel
   output logic                             rsp_valid,
   output logic [7:0]                       rsp_text_char,
   output logic                             rsp_last_char,
   // register port
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [sadt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire [31:0]                       pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   logic              tenths_mode_ff, tenths_mode_in;
   logic              csr_wr;
   sadt_pkg::job_type head;
   logic              empty;
   logic              pop;

   // register write and read back
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      tenths_mode_in = tenths_mode_ff;
      if (csr_wr && paddr == sadt_pkg::CSR_TENTHS_MODE) begin
         tenths_mode_in = pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == sadt_pkg::CSR_TENTHS_MODE) begin
         prdata = {31'd0, tenths_mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tenths_mode_ff <= sadt_pkg::TENTHS_MODE_RESET;
      end else begin
         tenths_mode_ff <= tenths_mode_in;
      end
   end

   sadt_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_value   (req_value),
      .tenths_mode (tenths_mode_ff),
      .pop         (pop),
      .head        (head),
      .empty       (empty)
   );

   sadt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
`default_nettype wire
